// ===== src/vba_pkg.sv =====
// shared types, widths and angle constants for the bearing block
package vba_pkg;

    localparam int DEFAULT_STAGES = 16;
    localparam int MAX_STAGES     = 24;

    localparam int IN_W   = 16;
    localparam int D_W    = IN_W + 1;
    localparam int ZFRAC  = 16;
    localparam int XY_W   = 36;
    localparam int Z_W    = 25;
    localparam int PHI_W  = 23;
    localparam int SUM_W  = 26;
    localparam int B_W    = 16;

    localparam int ANG_90  = 90 << ZFRAC;
    localparam int ANG_180 = 180 << ZFRAC;
    localparam int ANG_360 = 360 << ZFRAC;

    localparam int RND_SHIFT = ZFRAC - 7;
    localparam int RND_ADD   = 1 << (ZFRAC - 8);
    localparam int FULL_TURN = 360 << 7;

    typedef struct packed {
        logic dx_neg;
        logic dy_neg;
        logic zero;
    } side_t;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic signed [Z_W-1:0] atan_deg(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = 25'sd2949120;
            1:       v = 25'sd1740967;
            2:       v = 25'sd919879;
            3:       v = 25'sd466945;
            4:       v = 25'sd234379;
            5:       v = 25'sd117304;
            6:       v = 25'sd58666;
            7:       v = 25'sd29335;
            8:       v = 25'sd14668;
            9:       v = 25'sd7334;
            10:      v = 25'sd3667;
            11:      v = 25'sd1833;
            12:      v = 25'sd917;
            13:      v = 25'sd458;
            14:      v = 25'sd229;
            15:      v = 25'sd115;
            16:      v = 25'sd57;
            17:      v = 25'sd29;
            18:      v = 25'sd14;
            19:      v = 25'sd7;
            20:      v = 25'sd4;
            21:      v = 25'sd2;
            22:      v = 25'sd1;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/vba_prep.sv =====
// front stage: point difference, magnitudes, quadrant and coincidence flag
module vba_prep (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic signed [vba_pkg::IN_W-1:0]      target_x,
    input  logic signed [vba_pkg::IN_W-1:0]      target_y,
    input  logic signed [vba_pkg::IN_W-1:0]      object_x,
    input  logic signed [vba_pkg::IN_W-1:0]      object_y,
    output logic                                 out_valid,
    output logic signed [vba_pkg::XY_W-1:0]      out_x,
    output logic signed [vba_pkg::XY_W-1:0]      out_y,
    output vba_pkg::side_t                       out_side
);

    localparam int PAD_W = vba_pkg::XY_W - vba_pkg::D_W - vba_pkg::ZFRAC;

    logic signed [vba_pkg::D_W-1:0]  dx;
    logic signed [vba_pkg::D_W-1:0]  dy;
    logic [vba_pkg::D_W-1:0]         ax;
    logic [vba_pkg::D_W-1:0]         ay;
    logic                            valid_reg;
    logic signed [vba_pkg::XY_W-1:0] x_reg;
    logic signed [vba_pkg::XY_W-1:0] x_next;
    logic signed [vba_pkg::XY_W-1:0] y_reg;
    logic signed [vba_pkg::XY_W-1:0] y_next;
    vba_pkg::side_t                  side_reg;
    vba_pkg::side_t                  side_next;

    always_comb
    begin
        dx = {object_x[vba_pkg::IN_W-1], object_x} - {target_x[vba_pkg::IN_W-1], target_x};
        dy = {object_y[vba_pkg::IN_W-1], object_y} - {target_y[vba_pkg::IN_W-1], target_y};
        ax = dx[vba_pkg::D_W-1] ? vba_pkg::D_W'(-dx) : vba_pkg::D_W'(dx);
        ay = dy[vba_pkg::D_W-1] ? vba_pkg::D_W'(-dy) : vba_pkg::D_W'(dy);
        // x starts on the dy magnitude so the angle comes out from the +y axis
        x_next = $signed({{PAD_W{1'b0}}, ay, {vba_pkg::ZFRAC{1'b0}}});
        y_next = $signed({{PAD_W{1'b0}}, ax, {vba_pkg::ZFRAC{1'b0}}});
        side_next.dx_neg = dx[vba_pkg::D_W-1];
        side_next.dy_neg = dy[vba_pkg::D_W-1];
        side_next.zero   = (dx == '0) && (dy == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        side_reg <= side_next;
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_side  = side_reg;

endmodule

// ===== src/vba_cordic_stage.sv =====
// one registered vectoring iteration of the cordic
module vba_cordic_stage #(
    parameter int STAGE = 0
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic signed [vba_pkg::XY_W-1:0]      in_x,
    input  logic signed [vba_pkg::XY_W-1:0]      in_y,
    input  logic signed [vba_pkg::Z_W-1:0]       in_z,
    input  vba_pkg::side_t                       in_side,
    output logic                                 out_valid,
    output logic signed [vba_pkg::XY_W-1:0]      out_x,
    output logic signed [vba_pkg::XY_W-1:0]      out_y,
    output logic signed [vba_pkg::Z_W-1:0]       out_z,
    output vba_pkg::side_t                       out_side
);

    localparam logic signed [vba_pkg::Z_W-1:0] ATAN = vba_pkg::atan_deg(STAGE);

    logic signed [vba_pkg::XY_W-1:0] xs;
    logic signed [vba_pkg::XY_W-1:0] ys;
    logic                            valid_reg;
    logic signed [vba_pkg::XY_W-1:0] x_reg;
    logic signed [vba_pkg::XY_W-1:0] x_next;
    logic signed [vba_pkg::XY_W-1:0] y_reg;
    logic signed [vba_pkg::XY_W-1:0] y_next;
    logic signed [vba_pkg::Z_W-1:0]  z_reg;
    logic signed [vba_pkg::Z_W-1:0]  z_next;
    vba_pkg::side_t                  side_reg;

    always_comb
    begin
        xs = in_x >>> STAGE;
        ys = in_y >>> STAGE;
        // rotate towards the x axis, y at zero counts as positive
        if (!in_y[vba_pkg::XY_W-1])
        begin
            x_next = in_x + ys;
            y_next = in_y - xs;
            z_next = in_z + ATAN;
        end
        else
        begin
            x_next = in_x - ys;
            y_next = in_y + xs;
            z_next = in_z - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

endmodule

// ===== src/vba_post.sv =====
// back stage: clamp, quadrant placement and rounding to 7 fraction bits
module vba_post (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic signed [vba_pkg::Z_W-1:0]       in_z,
    input  vba_pkg::side_t                       in_side,
    output logic                                 out_valid,
    output logic [vba_pkg::B_W-1:0]              out_bearing,
    output logic                                 out_zero
);

    localparam logic [vba_pkg::PHI_W-1:0] PHI_MAX   = vba_pkg::PHI_W'(vba_pkg::ANG_90);
    localparam logic [vba_pkg::SUM_W-1:0] B_180     = vba_pkg::SUM_W'(vba_pkg::ANG_180);
    localparam logic [vba_pkg::SUM_W-1:0] B_360     = vba_pkg::SUM_W'(vba_pkg::ANG_360);
    localparam logic [vba_pkg::SUM_W-1:0] B_RND     = vba_pkg::SUM_W'(vba_pkg::RND_ADD);
    localparam logic [vba_pkg::B_W-1:0]   TURN      = vba_pkg::B_W'(vba_pkg::FULL_TURN);

    logic [vba_pkg::PHI_W-1:0] phi;
    logic [vba_pkg::SUM_W-1:0] phi_ext;
    logic [vba_pkg::SUM_W-1:0] b;
    logic [vba_pkg::SUM_W-1:0] b_rnd;
    logic [vba_pkg::B_W-1:0]   r;
    logic                      valid_reg;
    logic [vba_pkg::B_W-1:0]   bearing_reg;
    logic [vba_pkg::B_W-1:0]   bearing_next;
    logic                      zero_reg;

    always_comb
    begin
        if (in_z[vba_pkg::Z_W-1])
        begin
            phi = '0;
        end
        else if (in_z[vba_pkg::Z_W-2:0] > (vba_pkg::Z_W-1)'(PHI_MAX))
        begin
            phi = PHI_MAX;
        end
        else
        begin
            phi = in_z[vba_pkg::PHI_W-1:0];
        end

        phi_ext = vba_pkg::SUM_W'(phi);
        case ({in_side.dx_neg, in_side.dy_neg})
            2'b00:   b = phi_ext;
            2'b01:   b = B_180 - phi_ext;
            2'b11:   b = B_180 + phi_ext;
            default: b = B_360 - phi_ext;
        endcase

        b_rnd = b + B_RND;
        r     = b_rnd[vba_pkg::RND_SHIFT +: vba_pkg::B_W];

        // a full turn after rounding wraps to north
        if (in_side.zero || (r >= TURN))
        begin
            bearing_next = '0;
        end
        else
        begin
            bearing_next = r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        bearing_reg <= bearing_next;
        zero_reg    <= in_side.zero;
    end

    assign out_valid   = valid_reg;
    assign out_bearing = bearing_reg;
    assign out_zero    = zero_reg;

endmodule

// ===== src/vector_bearing_angle_top.sv =====
// top level: bearing of an object point from a target point
// done marks the result once the item has passed these registers in order:
// one front stage, one register per cordic iteration, one back stage
// throughput: one item per cycle, busy stays low as nothing can stall
// reset: rst_n clears every valid bit at once, no item in flight survives it
module vector_bearing_angle_top #(
    parameter int CORDIC_STAGES = vba_pkg::DEFAULT_STAGES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [vba_pkg::IN_W-1:0] target_x,
    input  logic signed [vba_pkg::IN_W-1:0] target_y,
    input  logic signed [vba_pkg::IN_W-1:0] object_x,
    input  logic signed [vba_pkg::IN_W-1:0] object_y,
    output logic                            done,
    output logic [vba_pkg::B_W-1:0]         bearing,
    output logic                            zero_vector
);

    logic                            valid_stage [0:CORDIC_STAGES];
    logic signed [vba_pkg::XY_W-1:0] x_stage     [0:CORDIC_STAGES];
    logic signed [vba_pkg::XY_W-1:0] y_stage     [0:CORDIC_STAGES];
    logic signed [vba_pkg::Z_W-1:0]  z_stage     [0:CORDIC_STAGES];
    vba_pkg::side_t                  side_stage  [0:CORDIC_STAGES];

    assign busy       = 1'b0;
    assign z_stage[0] = '0;

    vba_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .target_x  (target_x),
        .target_y  (target_y),
        .object_x  (object_x),
        .object_y  (object_y),
        .out_valid (valid_stage[0]),
        .out_x     (x_stage[0]),
        .out_y     (y_stage[0]),
        .out_side  (side_stage[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        vba_cordic_stage #(
            .STAGE (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_stage[i]),
            .in_x      (x_stage[i]),
            .in_y      (y_stage[i]),
            .in_z      (z_stage[i]),
            .in_side   (side_stage[i]),
            .out_valid (valid_stage[i+1]),
            .out_x     (x_stage[i+1]),
            .out_y     (y_stage[i+1]),
            .out_z     (z_stage[i+1]),
            .out_side  (side_stage[i+1])
        );
    end

    vba_post u_post (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (valid_stage[CORDIC_STAGES]),
        .in_z        (z_stage[CORDIC_STAGES]),
        .in_side     (side_stage[CORDIC_STAGES]),
        .out_valid   (done),
        .out_bearing (bearing),
        .out_zero    (zero_vector)
    );

`ifndef SYNTHESIS
    // every taken item comes out after the fixed pipeline depth
    assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(CORDIC_STAGES + 2) done)
        else $error("item lost in pipeline");

    // coincidence flag matches the points of the item it belongs to
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (zero_vector == $past((object_x == target_x) && (object_y == target_y),
                                       CORDIC_STAGES + 2)))
        else $error("zero flag out of step with its item");

    // bearing stays below a full turn and is north for coincident points
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((bearing < vba_pkg::B_W'(vba_pkg::FULL_TURN))
                  && (!zero_vector || (bearing == '0))))
        else $error("bearing out of range");
`endif

endmodule
